FILE: rtl/fpba_pkg.sv
// fpba_pkg: shared types and constants of the fit-policy block allocator
// used by fpba_cell and fit_policy_block_allocator_unit; no dependencies
package fpba_pkg;

    // fit mode codes; the unused code behaves as first fit
    localparam int unsigned FIT_MODE_W = 2;
    localparam logic [FIT_MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_MODE_W-1:0] FIT_WORST = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    // request sequence number width
    localparam int unsigned REQ_NUM_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fpba_state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                  scan;
        logic                  mark;
        logic [FIT_MODE_W-1:0] mode;
    } fpba_ctrl_t;

endpackage

FILE: rtl/fit_policy_block_allocator_unit.sv
// fit_policy_block_allocator_unit: top level, sequencer and chain of table cells
// depends on fpba_pkg and fpba_cell
// command channel: operation, entry_index and size_value with start high; the
//   transaction is taken at a rising edge where start is high and busy is low
// a load (operation 0) writes one entry, marks it free and gives no result;
//   busy stays low, so loads may follow back to back
// a request (operation 1) raises busy and scans the chain of MAX_BLOCKS cells,
//   one cell per cycle, then marks the chosen entry used in the finish state
// the result (granted, block_index, request_number) is registered in the finish
//   state and shown with done high for exactly one cycle, and is taken at the edge
//   that ends that cycle
// busy is already low while done is high, so the next command is taken at that
//   same edge; a new request is not taken until the chain walk and marking are done
// configuration: cfg_write with cfg_index and cfg_data, taken at any edge;
//   write only while the block is idle
// reset: all entries free, request counter zero, fit mode first fit and block
//   count zero; entry sizes are undefined until loaded
// the receiver cannot stall: done is a strobe and must be taken at once
module fit_policy_block_allocator_unit
    import fpba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 16,
    parameter int unsigned SIZE_WIDTH = 16,
    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS),
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1),
    localparam int unsigned CFG_W = (CNT_W > FIT_MODE_W) ? CNT_W : FIT_MODE_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // command channel
    input  logic                   start,
    output logic                   busy,
    input  logic                   operation,
    input  logic [IDX_W-1:0]       entry_index,
    input  logic [SIZE_WIDTH-1:0]  size_value,
    // result channel
    output logic                   done,
    output logic                   granted,
    output logic [IDX_W-1:0]       block_index,
    output logic [REQ_NUM_W-1:0]   request_number,
    // configuration port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_BLOCKS - 1);
    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_BLOCKS);

    fpba_state_t state_reg;
    fpba_state_t state_next;

    logic [FIT_MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      limit;

    logic [IDX_W-1:0]      step_reg;
    logic [IDX_W-1:0]      step_next;
    logic [SIZE_WIDTH-1:0] want_reg;
    logic [REQ_NUM_W-1:0]  counter_reg;
    logic [REQ_NUM_W-1:0]  req_num_reg;

    logic                  done_reg;
    logic                  done_next;
    logic                  granted_reg;
    logic [IDX_W-1:0]      block_index_reg;
    logic [REQ_NUM_W-1:0]  request_number_reg;

    logic                  accept;
    logic                  accept_load;
    logic                  accept_req;
    fpba_ctrl_t            ctrl;

    // candidate chain between cells
    logic                  cand_valid [MAX_BLOCKS];
    logic [SIZE_WIDTH-1:0] cand_size  [MAX_BLOCKS];
    logic [IDX_W-1:0]      cand_index [MAX_BLOCKS];
    logic                  last_valid;
    logic [IDX_W-1:0]      last_index;

    assign accept      = start && !busy;
    assign accept_load = accept && !operation;
    assign accept_req  = accept && operation;

    // block count above the table depth saturates
    assign limit = (count_reg > MAX_COUNT) ? MAX_COUNT : count_reg;

    assign last_valid = cand_valid[MAX_BLOCKS-1];
    assign last_index = cand_index[MAX_BLOCKS-1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= FIT_FIRST;
            count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FIT_MODE:    mode_reg  <= cfg_data[FIT_MODE_W-1:0];
                CFG_BLOCK_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            done_reg    <= 1'b0;
            counter_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            if (accept_req)
                counter_reg <= counter_reg + 1'b1;
        end
    end

    // next state and cell control
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        ctrl.scan  = 1'b0;
        ctrl.mark  = 1'b0;
        ctrl.mode  = mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_req)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
            end
            ST_SCAN:
            begin
                // one cell updates its candidate per cycle
                ctrl.scan = 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = ST_FINISH;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_FINISH:
            begin
                // chosen entry marked used, result registered for the strobe
                ctrl.mark  = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // request payload and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept_req)
        begin
            want_reg    <= size_value;
            req_num_reg <= counter_reg;
        end
        if (state_reg == ST_FINISH)
        begin
            granted_reg        <= last_valid;
            block_index_reg    <= last_valid ? last_index : '0;
            request_number_reg <= req_num_reg;
        end
    end

    // chain of table cells; cell 0 starts with no candidate
    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_cell
        logic              in_valid;
        logic [SIZE_WIDTH-1:0] in_size;
        logic [IDX_W-1:0]  in_index;

        if (k == 0)
        begin : g_head
            assign in_valid = 1'b0;
            assign in_size  = '0;
            assign in_index = '0;
        end
        else
        begin : g_link
            assign in_valid = cand_valid[k-1];
            assign in_size  = cand_size[k-1];
            assign in_index = cand_index[k-1];
        end

        fpba_cell #(
            .IDX_W      (IDX_W),
            .SIZE_W     (SIZE_WIDTH),
            .CNT_W      (CNT_W),
            .CELL_INDEX (k)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .load_en        (accept_load),
            .load_index     (entry_index),
            .load_size      (size_value),
            .step           (step_reg),
            .limit          (limit),
            .want           (want_reg),
            .mark_valid     (last_valid),
            .mark_index     (last_index),
            .cand_in_valid  (in_valid),
            .cand_in_size   (in_size),
            .cand_in_index  (in_index),
            .cand_out_valid (cand_valid[k]),
            .cand_out_size  (cand_size[k]),
            .cand_out_index (cand_index[k])
        );
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign granted        = granted_reg;
    assign block_index    = block_index_reg;
    assign request_number = request_number_reg;

endmodule

FILE: rtl/fpba_cell.sv
// fpba_cell: one table entry (size and used flag) and one stage of the candidate chain
// depends on fpba_pkg
module fpba_cell
    import fpba_pkg::*;
#(
    parameter int unsigned IDX_W      = 4,
    parameter int unsigned SIZE_W     = 16,
    parameter int unsigned CNT_W      = 5,
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpba_ctrl_t        ctrl,
    input  logic              load_en,
    input  logic [IDX_W-1:0]  load_index,
    input  logic [SIZE_W-1:0] load_size,
    input  logic [IDX_W-1:0]  step,
    input  logic [CNT_W-1:0]  limit,
    input  logic [SIZE_W-1:0] want,
    input  logic              mark_valid,
    input  logic [IDX_W-1:0]  mark_index,
    input  logic              cand_in_valid,
    input  logic [SIZE_W-1:0] cand_in_size,
    input  logic [IDX_W-1:0]  cand_in_index,
    output logic              cand_out_valid,
    output logic [SIZE_W-1:0] cand_out_size,
    output logic [IDX_W-1:0]  cand_out_index
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_COUNT = CNT_W'(CELL_INDEX);

    logic [SIZE_W-1:0] size_reg;
    logic              used_reg;
    logic              used_next;
    logic              cand_valid_reg;
    logic              cand_valid_next;
    logic [SIZE_W-1:0] cand_size_reg;
    logic [SIZE_W-1:0] cand_size_next;
    logic [IDX_W-1:0]  cand_index_reg;
    logic [IDX_W-1:0]  cand_index_next;
    logic              active;
    logic              fits;
    logic              take;

    assign active = ctrl.scan && (step == MY_INDEX);
    assign fits   = (MY_COUNT < limit) && !used_reg && (size_reg >= want);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!cand_in_valid)
                take = 1'b1;
            else if ((ctrl.mode == FIT_BEST) && (size_reg < cand_in_size))
                take = 1'b1;
            else if ((ctrl.mode == FIT_WORST) && (size_reg > cand_in_size))
                take = 1'b1;
        end
    end

    always_comb
    begin
        cand_valid_next = cand_valid_reg;
        cand_size_next  = cand_size_reg;
        cand_index_next = cand_index_reg;
        if (active)
        begin
            if (take)
            begin
                cand_valid_next = 1'b1;
                cand_size_next  = size_reg;
                cand_index_next = MY_INDEX;
            end
            else
            begin
                cand_valid_next = cand_in_valid;
                cand_size_next  = cand_in_size;
                cand_index_next = cand_in_index;
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (load_en && (load_index == MY_INDEX))
            used_next = 1'b0;
        else if (ctrl.mark && mark_valid && (mark_index == MY_INDEX))
            used_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= 1'b0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            cand_valid_reg <= cand_valid_next;
        end
    end

    // payload, no reset: entry size is undefined until loaded
    always_ff @(posedge clk)
    begin
        if (load_en && (load_index == MY_INDEX))
            size_reg <= load_size;
        cand_size_reg  <= cand_size_next;
        cand_index_reg <= cand_index_next;
    end

    assign cand_out_valid = cand_valid_reg;
    assign cand_out_size  = cand_size_reg;
    assign cand_out_index = cand_index_reg;

endmodule
